// ===== src/sdsw_pkg.sv =====
`timescale 1ns / 1ps

package sdsw_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int VALUE_W    = 28;
    localparam int POS_W      = 4;
    localparam int MAG_W      = VALUE_W - 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // exact divide by ten for any magnitude below 2^32
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = MAG_W + 32;
    localparam int          QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] GRID_BASE = 8'hC0;
    localparam logic [7:0] GRID_STEP = 8'h02;

    function automatic longint pow_ten(int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam logic signed [VALUE_W-1:0] VALUE_HI = VALUE_W'(pow_ten(NUM_DIGITS) - 1);
    localparam logic signed [VALUE_W-1:0] VALUE_LO = VALUE_W'(-(pow_ten(NUM_DIGITS - 1) - 1));

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          start_position;
    } item_t;

    typedef struct packed {
        logic [7:0] grid_address;
        logic [7:0] segment_pattern;
        logic       last;
    } result_t;

    // classified request between front and back
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [POS_W-1:0] pos;
        logic             armed;
    } req_t;

    function automatic logic [7:0] seg_of_digit(logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== src/sdsw_front.sv =====
`timescale 1ns / 1ps

module sdsw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  sdsw_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_stall,
    output sdsw_pkg::req_t    req,
    output logic              req_valid,
    input  logic              req_stall
);

    logic                                  armed_reg;
    logic                                  armed_next;
    logic                                  in_range;
    logic                                  accept;
    logic signed [sdsw_pkg::VALUE_W-1:0]   neg_value;

    assign in_range  = !($signed(item.value) > sdsw_pkg::VALUE_HI) &&
                       !($signed(item.value) < sdsw_pkg::VALUE_LO);
    assign neg_value = -$signed(item.value);

    assign item_stall = req_stall;
    assign accept     = item_valid && !item_stall;

    // out of range requests are swallowed here
    assign req_valid = item_valid && in_range;

    always_comb
    begin
        req.neg   = item.value[sdsw_pkg::VALUE_W-1];
        req.mag   = item.value[sdsw_pkg::VALUE_W-1] ? neg_value[sdsw_pkg::MAG_W-1:0]
                                                    : item.value[sdsw_pkg::MAG_W-1:0];
        req.pos   = item.start_position;
        req.armed = armed_reg;
    end

    always_comb
    begin
        armed_next = armed_reg;
        if (accept && in_range)
        begin
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
        end
    end

endmodule

// ===== src/sdsw_queue.sv =====
`timescale 1ns / 1ps

module sdsw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sdsw_pkg::req_t    push_req,
    input  logic              push_valid,
    output logic              push_stall,
    output sdsw_pkg::req_t    pop_req,
    output logic              pop_valid,
    input  logic              pop_stall
);

    sdsw_pkg::req_t                 entry_reg [sdsw_pkg::QDEPTH];
    logic [sdsw_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sdsw_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [sdsw_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sdsw_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [sdsw_pkg::QCNT_W-1:0]    count_reg;
    logic [sdsw_pkg::QCNT_W-1:0]    count_next;
    logic                           push;
    logic                           pop;

    assign push_stall = (count_reg == sdsw_pkg::QCNT_W'(sdsw_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sdsw_pkg::QPTR_W'(sdsw_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + sdsw_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sdsw_pkg::QPTR_W'(sdsw_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + sdsw_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + sdsw_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - sdsw_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/sdsw_back.sv =====
`timescale 1ns / 1ps

module sdsw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sdsw_pkg::req_t    req,
    input  logic              req_valid,
    output logic              req_stall,
    output sdsw_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int N = sdsw_pkg::NUM_DIGITS;

    // digit converter: one divide by ten a cycle, least significant digit first
    logic                           conv_busy_reg;
    logic                           conv_busy_next;
    logic [sdsw_pkg::CNT_W-1:0]     conv_cnt_reg;
    logic [sdsw_pkg::CNT_W-1:0]     conv_cnt_next;
    logic [sdsw_pkg::MAG_W-1:0]     mag_reg;
    logic [sdsw_pkg::MAG_W-1:0]     mag_next;
    sdsw_pkg::req_t                 conv_req_reg;
    logic [3:0]                     digs_reg [N];
    logic                           conv_done;
    logic                           conv_step;
    logic                           pop;
    logic [sdsw_pkg::MAG_W-1:0]     div_in;
    logic [sdsw_pkg::PROD_W-1:0]    prod;
    logic [sdsw_pkg::QUO_W-1:0]     quo;
    logic [3:0]                     quo_ten_lo;
    logic [3:0]                     rem;

    // blanking and slot selection at hand-over
    logic                           zrun;
    logic                           srun;
    logic [N-1:0]                   blank;
    logic [sdsw_pkg::IDX_W-1:0]     load_start;
    logic [7:0]                     load_pat [N];
    logic [7:0]                     load_addr;

    // emitter
    logic                           emit_active_reg;
    logic                           emit_active_next;
    logic [sdsw_pkg::IDX_W-1:0]     idx_reg;
    logic [sdsw_pkg::IDX_W-1:0]     idx_next;
    logic [7:0]                     addr_reg;
    logic [7:0]                     addr_next;
    logic [7:0]                     pat_reg [N];
    logic                           emit_last;
    logic                           advance;
    logic                           xfer;

    // output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    sdsw_pkg::result_t              out_reg;
    sdsw_pkg::result_t              out_next;

    assign conv_done = conv_busy_reg && (conv_cnt_reg == sdsw_pkg::CNT_W'(N));
    assign emit_last = (idx_reg == sdsw_pkg::IDX_W'(N - 1));
    assign advance   = emit_active_reg && (!out_valid_reg || !result_stall);
    assign xfer      = conv_done && (!emit_active_reg || (advance && emit_last));
    assign req_stall = conv_busy_reg && !xfer;
    assign pop       = req_valid && !req_stall;
    assign conv_step = pop || (conv_busy_reg && (conv_cnt_reg != sdsw_pkg::CNT_W'(N)));

    // first division happens in the cycle the request is taken
    assign div_in     = pop ? req.mag : mag_reg;
    assign prod       = sdsw_pkg::PROD_W'(div_in) * sdsw_pkg::PROD_W'(sdsw_pkg::RECIP_TEN);
    assign quo        = prod[sdsw_pkg::PROD_W-1:sdsw_pkg::RECIP_SHIFT];
    assign quo_ten_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
    assign rem        = div_in[3:0] - quo_ten_lo;

    always_comb
    begin
        conv_busy_next = conv_busy_reg;
        conv_cnt_next  = conv_cnt_reg;
        mag_next       = mag_reg;
        if (conv_step)
        begin
            mag_next      = sdsw_pkg::MAG_W'(quo);
            conv_cnt_next = pop ? sdsw_pkg::CNT_W'(1) : conv_cnt_reg + sdsw_pkg::CNT_W'(1);
        end
        if (pop)
        begin
            conv_busy_next = 1'b1;
        end
        else if (xfer)
        begin
            conv_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            conv_req_reg <= req;
        end
        if (conv_step)
        begin
            digs_reg[0] <= rem;
            for (int i = 1; i < N; i++)
            begin
                digs_reg[i] <= digs_reg[i-1];
            end
        end
        mag_reg <= mag_next;
    end

    // once blanking is armed, leading zeros after the sign become blank; the last digit always shows
    always_comb
    begin
        zrun       = conv_req_reg.armed;
        srun       = 1'b1;
        blank      = '0;
        load_start = '0;
        for (int i = 0; i < N - 1; i++)
        begin
            if (!(conv_req_reg.neg && (i == 0)))
            begin
                zrun     = zrun && (digs_reg[i] == 4'd0);
                blank[i] = zrun;
            end
        end
        for (int i = 0; i < N - 1; i++)
        begin
            srun = srun && blank[i];
            if (srun)
            begin
                load_start = load_start + sdsw_pkg::IDX_W'(1);
            end
        end
        for (int i = 0; i < N; i++)
        begin
            if (conv_req_reg.neg && (i == 0))
            begin
                load_pat[i] = sdsw_pkg::SEG_MINUS;
            end
            else if (blank[i])
            begin
                load_pat[i] = sdsw_pkg::SEG_BLANK;
            end
            else
            begin
                load_pat[i] = sdsw_pkg::seg_of_digit(digs_reg[i]);
            end
        end
        load_addr = sdsw_pkg::GRID_BASE + 8'({conv_req_reg.pos, 1'b0}) - sdsw_pkg::GRID_STEP;
    end

    always_comb
    begin
        emit_active_next = emit_active_reg;
        idx_next         = idx_reg;
        addr_next        = addr_reg;
        if (xfer)
        begin
            emit_active_next = 1'b1;
            idx_next         = load_start;
            addr_next        = load_addr;
        end
        else if (advance)
        begin
            if (emit_last)
            begin
                emit_active_next = 1'b0;
            end
            else
            begin
                idx_next  = idx_reg + sdsw_pkg::IDX_W'(1);
                addr_next = addr_reg + sdsw_pkg::GRID_STEP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            for (int i = 0; i < N; i++)
            begin
                pat_reg[i] <= load_pat[i];
            end
        end
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next           = 1'b1;
            out_next.grid_address    = addr_reg;
            out_next.segment_pattern = pat_reg[idx_reg];
            out_next.last            = emit_last;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg   <= 1'b0;
            conv_cnt_reg    <= '0;
            emit_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            conv_busy_reg   <= conv_busy_next;
            conv_cnt_reg    <= conv_cnt_next;
            emit_active_reg <= emit_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        conv_busy_reg |-> (conv_cnt_reg != '0) && (conv_cnt_reg <= sdsw_pkg::CNT_W'(N)))
        else $error("converter count out of range");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> emit_active_reg)
        else $error("write without last but emitter idle");

    a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |-> (out_reg.segment_pattern != sdsw_pkg::SEG_BLANK))
        else $error("final write is blank");

    a_xfer_done: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |=> emit_active_reg && (conv_busy_reg == $past(pop)))
        else $error("hand-over to emitter lost");

endmodule

// ===== src/signed_decimal_seven_segment_writer.sv =====
`timescale 1ns / 1ps
// the first display write follows the digit converter, the hand-over to the emitter and the output register
// a request holds the digit converter, doing one divide by ten a cycle, until it is handed to the emitter
// writes leave one per cycle while result_stall is low, up to 8 per request, while the next request is converted
// out of range requests are taken while the queue has room and give no write
// reset clears the busy, valid, count and pointer state; leading zero blanking starts disarmed

module signed_decimal_seven_segment_writer (
    input  logic              clk,
    input  logic              rst_n,
    input  sdsw_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_stall,
    output sdsw_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);

    sdsw_pkg::req_t front_req;
    logic           front_valid;
    logic           front_stall;
    sdsw_pkg::req_t back_req;
    logic           back_valid;
    logic           back_stall;

    sdsw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .req        (front_req),
        .req_valid  (front_valid),
        .req_stall  (front_stall)
    );

    sdsw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_req   (front_req),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .pop_req    (back_req),
        .pop_valid  (back_valid),
        .pop_stall  (back_stall)
    );

    sdsw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (back_req),
        .req_valid    (back_valid),
        .req_stall    (back_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int VALUE_MAX = 99999999;
    localparam int VALUE_MIN = -9999999;
    localparam int TEN_POW [9] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
                                   100000000};
    localparam logic [7:0] DIGIT_SEG [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                              8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    sdsw_pkg::item_t   item = '0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    sdsw_pkg::result_t result;
    logic              result_valid;
    logic              result_stall = 1'b0;

    sdsw_pkg::result_t expected_writes [$];
    bit      blank_leading_zeros;
    bit      send_idle;
    bit      recv_idle;
    int      hold_cycles = 0;
    int      error_count;
    int      numbers_sent;
    int      numbers_dropped;
    int      numbers_negative;
    int      writes_checked;

    signed_decimal_seven_segment_writer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // display writes that one request should produce
    function automatic void predict_writes(input sdsw_pkg::item_t req);
        logic [7:0]        pat [sdsw_pkg::NUM_DIGITS];
        bit                blank [sdsw_pkg::NUM_DIGITS];
        int                number;
        int                mag;
        int                first;
        int                lead;
        int                count;
        sdsw_pkg::result_t w;
        number = int'($signed(req.value));
        if (number > VALUE_MAX || number < VALUE_MIN)
        begin
            numbers_dropped++;
            return;
        end
        for (int i = 0; i < sdsw_pkg::NUM_DIGITS; i++)
        begin
            pat[i] = sdsw_pkg::SEG_BLANK;
            blank[i] = 1'b0;
        end
        first = 0;
        mag = number;
        if (number < 0)
        begin
            numbers_negative++;
            mag = -number;
            first = 1;
            pat[0] = sdsw_pkg::SEG_MINUS;
        end
        for (int i = sdsw_pkg::NUM_DIGITS - 1; i >= first; i--)
        begin
            pat[i] = DIGIT_SEG[mag % 10];
            mag = mag / 10;
        end
        // the final digit always stays visible
        if (blank_leading_zeros)
        begin
            for (int i = first; i < sdsw_pkg::NUM_DIGITS - 1; i++)
            begin
                if (pat[i] != DIGIT_SEG[0])
                    break;
                pat[i] = sdsw_pkg::SEG_BLANK;
                blank[i] = 1'b1;
            end
        end
        blank_leading_zeros = 1'b1;
        // only blanks ahead of the first character are dropped
        lead = 0;
        while (lead < sdsw_pkg::NUM_DIGITS - 1 && blank[lead])
            lead++;
        count = sdsw_pkg::NUM_DIGITS - lead;
        for (int k = 0; k < count; k++)
        begin
            w.grid_address = sdsw_pkg::GRID_BASE +
                             8'(2 * (int'(req.start_position) - 1 + k));
            w.segment_pattern = pat[lead + k];
            w.last = (k == count - 1);
            expected_writes.push_back(w);
        end
    endfunction

    task automatic check_write(input sdsw_pkg::result_t got);
        sdsw_pkg::result_t want;
        if (expected_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write addr %h seg %h last %b",
                                      got.grid_address, got.segment_pattern, got.last));
            return;
        end
        want = expected_writes.pop_front();
        writes_checked++;
        if (got.grid_address !== want.grid_address)
            report_mismatch($sformatf("grid_address %h, expected %h",
                                      got.grid_address, want.grid_address));
        if (got.segment_pattern !== want.segment_pattern)
            report_mismatch($sformatf("segment_pattern %h, expected %h at addr %h",
                                      got.segment_pattern, want.segment_pattern,
                                      want.grid_address));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b at addr %h",
                                      got.last, want.last, want.grid_address));
    endtask

    task automatic send_number(input int number, input int grid);
        sdsw_pkg::item_t req;
        int              gap;
        req.value = sdsw_pkg::VALUE_W'(number);
        req.start_position = sdsw_pkg::POS_W'(grid);
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        predict_writes(req);
        numbers_sent++;
    endtask

    task automatic drain_writes();
        item_valid <= 1'b0;
        while (expected_writes.size() != 0 || hold_cycles != 0)
            @(posedge clk);
    endtask

    function automatic int pick_number();
        int digits;
        digits = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
            0: return int'($urandom);
            1:
            begin
                if ($urandom_range(0, 1))
                    return VALUE_MAX + 1 + int'($urandom_range(0, 999));
                return VALUE_MIN - 1 - int'($urandom_range(0, 999));
            end
            2, 3:
            begin
                digits = $urandom_range(1, 7);
                return -int'($urandom_range(1, TEN_POW[digits] - 1));
            end
            default: return int'($urandom_range(0, TEN_POW[digits] - 1));
        endcase
    endfunction

    function automatic int pick_grid();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(1, 8);
    endfunction

    // out of range first leaves blanking disarmed, so -42 still shows its zeros
    task automatic test_first_after_reset();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_number(100000000, 1);
        send_number(-42, 1);
        send_number(0, 1);
        drain_writes();
    endtask

    task automatic test_directed_extremes();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_number(VALUE_MAX, 1);
        send_number(VALUE_MIN, 1);
        send_number(VALUE_MIN - 1, 1);
        send_number(134217727, 1);
        send_number(-134217728, 4);
        send_number(12345678, 1);
        send_number(-1234567, 1);
        send_number(-5, 3);
        send_number(7, 8);
        send_number(42, 0);
        send_number(1000, 15);
        send_number(9, 9);
        send_number(-1, 0);
        send_number(10000000, 1);
        send_number(80808080, 2);
        send_number(5, 1);
        drain_writes();
    endtask

    // output held back long enough for the block to back up into its input
    task automatic test_output_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_cycles <= 250;
        for (int n = 0; n < 24; n++)
            send_number(pick_number(), pick_grid());
        drain_writes();
    endtask

    task automatic test_random_traffic(input int count, input bit src_idle, input bit dst_idle);
        send_idle = src_idle;
        recv_idle = dst_idle;
        for (int n = 0; n < count; n++)
            send_number(pick_number(), pick_grid());
        drain_writes();
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                check_write(result);
                stall_left = recv_idle ? $urandom_range(0, 9) : 0;
            end
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        blank_leading_zeros = 1'b0;
        error_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_after_reset();
        test_directed_extremes();
        test_output_backpressure();
        test_random_traffic(120, 1'b1, 1'b1);
        test_random_traffic(100, 1'b0, 1'b0);
        test_random_traffic(100, 1'b1, 1'b0);
        test_random_traffic(100, 1'b0, 1'b1);

        repeat (30) @(posedge clk);
        if (expected_writes.size() != 0)
            report_mismatch($sformatf("%0d display writes never arrived",
                                      expected_writes.size()));
        $display("sent %0d numbers: %0d out of range, %0d negative; %0d display writes checked",
                 numbers_sent, numbers_dropped, numbers_negative, writes_checked);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("signed_decimal_seven_segment_writer regression: pass");
        else
            $display("signed_decimal_seven_segment_writer regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting on the block");
        $display("signed_decimal_seven_segment_writer regression: fail");
        $finish;
    end

endmodule
